// ===== sv/tpcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tpcf_pkg
// Shared constants and status codes for the three-point circle fit.
// ----------------------------------------------------------------------------
package tpcf_pkg;

  localparam int TPCF_COORD_WIDTH = 16;
  localparam int MIN_DET_W        = 16;
  localparam logic [MIN_DET_W-1:0] MIN_DET_RESET = 16'd1;

  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_VALID     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COLLINEAR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

endpackage

// ===== sv/three_point_circle_fit.sv =====
// ----------------------------------------------------------------------------
// three_point_circle_fit
// Circumcircle (center and radius) of three signed fixed-point points.
// ----------------------------------------------------------------------------
// Fully pipelined: one point triple is taken every cycle while no output
// beat is stalled. The pipeline depth is set by the two restoring dividers
// (COORD_WIDTH+2 stages, one quotient bit each) and the digit-by-digit square
// root (COORD_WIDTH+1 stages), plus 14 stages of products, sums and clamping.
// A stalled output beat freezes the whole pipe; no beat is dropped or
// repeated. Quotients and radius round to nearest, ties away from zero. If
// |det| is zero or below min_determinant the result is 0,0,0 with collinear
// status; an out-of-range center or radius saturates and reports saturated
// status. Fraction bits do not change the arithmetic: all math is exact on
// raw fixed-point values.
module three_point_circle_fit
  import tpcf_pkg::*;
#(
  parameter int COORD_WIDTH = TPCF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [MIN_DET_W-1:0]          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_first_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_y,
  input  logic signed [COORD_WIDTH-1:0] in_third_x,
  input  logic signed [COORD_WIDTH-1:0] in_third_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_center_x,
  output logic signed [COORD_WIDTH-1:0] out_center_y,
  output logic [COORD_WIDTH-1:0]        out_circle_radius,
  output logic [STATUS_W-1:0]           out_fit_status
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;        // coordinate differences
  localparam int EW   = 2 * CW + 3;    // e2, f2, det
  localparam int PW   = DW + EW;       // second-level products
  localparam int NSW  = PW + 1;        // signed numerators
  localparam int NW   = PW + 2;        // dividend magnitude
  localparam int DVW  = EW + 1;        // 2*|det|
  localparam int QBW  = CW + 2;        // quotient bits, top bit = overflow
  localparam int XW   = CW + 3;        // signed center before clamp, dx
  localparam int VW   = 2 * CW + 2;    // radius squared and root state
  localparam int NS   = 2 * CW + 17;   // pipeline depth

  localparam logic signed [XW-1:0] CMAX = {4'b0000, {(CW-1){1'b1}}};
  localparam logic signed [XW-1:0] CMIN = {4'b1111, {(CW-1){1'b0}}};

  logic                 adv;
  logic [NS-1:0]        vld_r;
  logic [MIN_DET_W-1:0] min_det_r;

  assign adv      = !(vld_r[NS-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      min_det_r <= MIN_DET_RESET;
    end else begin
      if (adv) vld_r <= {vld_r[NS-2:0], in_valid};
      if (cfg_we) min_det_r <= cfg_wr_data;
    end
  end

  // stage 1: differences and sums
  logic signed [CW-1:0] x1_r1, y1_r1;
  logic signed [DW-1:0] a_r1, b_r1, c_r1, d_r1, sx12_r1, sy12_r1, sx13_r1, sy13_r1;

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r1   <= in_first_x;
      y1_r1   <= in_first_y;
      a_r1    <= DW'(in_first_x) - DW'(in_second_x);
      b_r1    <= DW'(in_first_y) - DW'(in_second_y);
      c_r1    <= DW'(in_first_x) - DW'(in_third_x);
      d_r1    <= DW'(in_first_y) - DW'(in_third_y);
      sx12_r1 <= DW'(in_first_x) + DW'(in_second_x);
      sy12_r1 <= DW'(in_first_y) + DW'(in_second_y);
      sx13_r1 <= DW'(in_first_x) + DW'(in_third_x);
      sy13_r1 <= DW'(in_first_y) + DW'(in_third_y);
    end
  end

  // stage 2: first products
  logic signed [CW-1:0]   x1_r2, y1_r2;
  logic signed [DW-1:0]   a_r2, b_r2, c_r2, d_r2;
  logic signed [2*DW-1:0] pe1_r2, pe2_r2, pf1_r2, pf2_r2, pbc_r2, pad_r2;

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r2  <= x1_r1;
      y1_r2  <= y1_r1;
      a_r2   <= a_r1;
      b_r2   <= b_r1;
      c_r2   <= c_r1;
      d_r2   <= d_r1;
      pe1_r2 <= (2*DW)'(a_r1) * (2*DW)'(sx12_r1);
      pe2_r2 <= (2*DW)'(b_r1) * (2*DW)'(sy12_r1);
      pf1_r2 <= (2*DW)'(c_r1) * (2*DW)'(sx13_r1);
      pf2_r2 <= (2*DW)'(d_r1) * (2*DW)'(sy13_r1);
      pbc_r2 <= (2*DW)'(b_r1) * (2*DW)'(c_r1);
      pad_r2 <= (2*DW)'(a_r1) * (2*DW)'(d_r1);
    end
  end

  // stage 3: e2, f2, det
  logic signed [CW-1:0] x1_r3, y1_r3;
  logic signed [DW-1:0] a_r3, b_r3, c_r3, d_r3;
  logic signed [EW-1:0] e2_r3, f2_r3, det_r3;

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r3  <= x1_r2;
      y1_r3  <= y1_r2;
      a_r3   <= a_r2;
      b_r3   <= b_r2;
      c_r3   <= c_r2;
      d_r3   <= d_r2;
      e2_r3  <= EW'(pe1_r2) + EW'(pe2_r2);
      f2_r3  <= EW'(pf1_r2) + EW'(pf2_r2);
      det_r3 <= EW'(pbc_r2) - EW'(pad_r2);
    end
  end

  // stage 4: numerator products, |det| and collinear test
  logic signed [CW-1:0] x1_r4, y1_r4;
  logic signed [PW-1:0] mde_r4, mbf_r4, maf_r4, mce_r4;
  logic [EW-1:0]        adet_r4;
  logic                 detpos_r4, coll_r4;
  logic [EW-1:0]        adet_nxt;

  assign adet_nxt = det_r3[EW-1] ? EW'(-det_r3) : EW'(det_r3);

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r4     <= x1_r3;
      y1_r4     <= y1_r3;
      mde_r4    <= PW'(d_r3) * PW'(e2_r3);
      mbf_r4    <= PW'(b_r3) * PW'(f2_r3);
      maf_r4    <= PW'(a_r3) * PW'(f2_r3);
      mce_r4    <= PW'(c_r3) * PW'(e2_r3);
      adet_r4   <= adet_nxt;
      detpos_r4 <= !det_r3[EW-1] && (det_r3 != '0);
      coll_r4   <= (det_r3 == '0) || (adet_nxt < EW'(min_det_r));
    end
  end

  // stage 5: numerators
  logic signed [CW-1:0]  x1_r5, y1_r5;
  logic signed [NSW-1:0] nx_r5, ny_r5;
  logic [EW-1:0]         adet_r5;
  logic                  detpos_r5, coll_r5;

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r5     <= x1_r4;
      y1_r5     <= y1_r4;
      nx_r5     <= NSW'(mde_r4) - NSW'(mbf_r4);
      ny_r5     <= NSW'(maf_r4) - NSW'(mce_r4);
      adet_r5   <= adet_r4;
      detpos_r5 <= detpos_r4;
      coll_r5   <= coll_r4;
    end
  end

  // stage 6: magnitudes and quotient signs
  logic signed [CW-1:0] x1_r6, y1_r6;
  logic [NSW-1:0]       ux_r6, uy_r6;
  logic [EW-1:0]        adet_r6;
  logic                 negx_r6, negy_r6, coll_r6;

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r6   <= x1_r5;
      y1_r6   <= y1_r5;
      ux_r6   <= nx_r5[NSW-1] ? NSW'(-nx_r5) : NSW'(nx_r5);
      uy_r6   <= ny_r5[NSW-1] ? NSW'(-ny_r5) : NSW'(ny_r5);
      adet_r6 <= adet_r5;
      negx_r6 <= nx_r5[NSW-1] ^ detpos_r5;
      negy_r6 <= ny_r5[NSW-1] ^ detpos_r5;
      coll_r6 <= coll_r5;
    end
  end

  // stage 7 feeds the dividers: q = (|n| + |det|) / (2|det|)
  logic [NW-1:0]        rx_d [QBW+1];
  logic [NW-1:0]        ry_d [QBW+1];
  logic [QBW-1:0]       qx_d [QBW+1];
  logic [QBW-1:0]       qy_d [QBW+1];
  logic [DVW-1:0]       dv_d [QBW+1];
  logic signed [CW-1:0] x1_d [QBW+1];
  logic signed [CW-1:0] y1_d [QBW+1];
  logic                 negx_d [QBW+1];
  logic                 negy_d [QBW+1];
  logic                 coll_d [QBW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rx_d[0]   <= NW'(ux_r6) + NW'(adet_r6);
      ry_d[0]   <= NW'(uy_r6) + NW'(adet_r6);
      qx_d[0]   <= '0;
      qy_d[0]   <= '0;
      dv_d[0]   <= {adet_r6, 1'b0};
      x1_d[0]   <= x1_r6;
      y1_d[0]   <= y1_r6;
      negx_d[0] <= negx_r6;
      negy_d[0] <= negy_r6;
      coll_d[0] <= coll_r6;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar g = 0; g < QBW; g++) begin : g_div
    localparam int K = QBW - 1 - g;
    logic [NW-1:0] dsh;
    logic          bx, by;

    assign dsh = NW'(dv_d[g]) << K;
    assign bx  = rx_d[g] >= dsh;
    assign by  = ry_d[g] >= dsh;

    always_ff @(posedge clk) begin
      if (adv) begin
        rx_d[g+1]   <= bx ? rx_d[g] - dsh : rx_d[g];
        ry_d[g+1]   <= by ? ry_d[g] - dsh : ry_d[g];
        qx_d[g+1]   <= {qx_d[g][QBW-2:0], bx};
        qy_d[g+1]   <= {qy_d[g][QBW-2:0], by};
        dv_d[g+1]   <= dv_d[g];
        x1_d[g+1]   <= x1_d[g];
        y1_d[g+1]   <= y1_d[g];
        negx_d[g+1] <= negx_d[g];
        negy_d[g+1] <= negy_d[g];
        coll_d[g+1] <= coll_d[g];
      end
    end
  end

  // stage A: signed center, magnitude beyond radius range
  logic signed [CW-1:0] x1_ra, y1_ra;
  logic signed [XW-1:0] x0_ra, y0_ra;
  logic                 big_ra, coll_ra;

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_ra   <= x1_d[QBW];
      y1_ra   <= y1_d[QBW];
      x0_ra   <= negx_d[QBW] ? -XW'(qx_d[QBW]) : XW'(qx_d[QBW]);
      y0_ra   <= negy_d[QBW] ? -XW'(qy_d[QBW]) : XW'(qy_d[QBW]);
      big_ra  <= (qx_d[QBW][QBW-1:CW] != '0) || (qy_d[QBW][QBW-1:CW] != '0);
      coll_ra <= coll_d[QBW];
    end
  end

  // stage B: clamp center, offsets from first point
  logic signed [CW-1:0] cx_rb, cy_rb;
  logic signed [XW-1:0] dx_rb, dy_rb;
  logic                 satc_rb, rsat_rb, coll_rb;

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_rb   <= (x0_ra > CMAX) ? CMAX[CW-1:0] : (x0_ra < CMIN) ? CMIN[CW-1:0] : x0_ra[CW-1:0];
      cy_rb   <= (y0_ra > CMAX) ? CMAX[CW-1:0] : (y0_ra < CMIN) ? CMIN[CW-1:0] : y0_ra[CW-1:0];
      satc_rb <= (x0_ra > CMAX) || (x0_ra < CMIN) || (y0_ra > CMAX) || (y0_ra < CMIN);
      dx_rb   <= XW'(x1_ra) - x0_ra;
      dy_rb   <= XW'(y1_ra) - y0_ra;
      rsat_rb <= big_ra;
      coll_rb <= coll_ra;
    end
  end

  // stage C: offset magnitudes
  logic signed [CW-1:0] cx_rc, cy_rc;
  logic [XW-1:0]        adx_rc, ady_rc;
  logic                 satc_rc, rsat_rc, coll_rc;

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_rc   <= cx_rb;
      cy_rc   <= cy_rb;
      adx_rc  <= dx_rb[XW-1] ? XW'(-dx_rb) : XW'(dx_rb);
      ady_rc  <= dy_rb[XW-1] ? XW'(-dy_rb) : XW'(dy_rb);
      satc_rc <= satc_rb;
      rsat_rc <= rsat_rb;
      coll_rc <= coll_rb;
    end
  end

  // stage D: squares
  logic signed [CW-1:0] cx_rd, cy_rd;
  logic [2*CW-1:0]      sqx_rd, sqy_rd;
  logic                 satc_rd, rsat_rd, coll_rd;

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_rd   <= cx_rc;
      cy_rd   <= cy_rc;
      sqx_rd  <= (2*CW)'(adx_rc[CW-1:0]) * (2*CW)'(adx_rc[CW-1:0]);
      sqy_rd  <= (2*CW)'(ady_rc[CW-1:0]) * (2*CW)'(ady_rc[CW-1:0]);
      satc_rd <= satc_rc;
      rsat_rd <= rsat_rc || (adx_rc[XW-1:CW] != '0) || (ady_rc[XW-1:CW] != '0);
      coll_rd <= coll_rc;
    end
  end

  // stage E feeds the square root
  logic [VW-1:0]        rem_s  [CW+2];
  logic [VW-1:0]        res_s  [CW+2];
  logic signed [CW-1:0] cx_s   [CW+2];
  logic signed [CW-1:0] cy_s   [CW+2];
  logic                 satc_s [CW+2];
  logic                 rsat_s [CW+2];
  logic                 coll_s [CW+2];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_s[0]  <= VW'(sqx_rd) + VW'(sqy_rd);
      res_s[0]  <= '0;
      cx_s[0]   <= cx_rd;
      cy_s[0]   <= cy_rd;
      satc_s[0] <= satc_rd;
      rsat_s[0] <= rsat_rd;
      coll_s[0] <= coll_rd;
    end
  end

  // digit-by-digit root, one result bit per stage
  for (genvar h = 0; h <= CW; h++) begin : g_sqrt
    localparam int I = CW - h;
    logic [VW-1:0] bitv, trial;
    logic          take;

    assign bitv  = VW'(1) << (2 * I);
    assign trial = res_s[h] + bitv;
    assign take  = rem_s[h] >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_s[h+1]  <= take ? rem_s[h] - trial : rem_s[h];
        res_s[h+1]  <= take ? (res_s[h] >> 1) + bitv : res_s[h] >> 1;
        cx_s[h+1]   <= cx_s[h];
        cy_s[h+1]   <= cy_s[h];
        satc_s[h+1] <= satc_s[h];
        rsat_s[h+1] <= rsat_s[h];
        coll_s[h+1] <= coll_s[h];
      end
    end
  end

  // stage R: round the root
  logic signed [CW-1:0] cx_rr, cy_rr;
  logic [VW-1:0]        rad_rr;
  logic                 satc_rr, rsat_rr, coll_rr;

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_rr   <= cx_s[CW+1];
      cy_rr   <= cy_s[CW+1];
      rad_rr  <= res_s[CW+1] + VW'(rem_s[CW+1] > res_s[CW+1]);
      satc_rr <= satc_s[CW+1];
      rsat_rr <= rsat_s[CW+1];
      coll_rr <= coll_s[CW+1];
    end
  end

  // output register
  logic rsat_fin;
  assign rsat_fin = rsat_rr || (rad_rr[VW-1:CW] != '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (coll_rr) begin
        out_center_x      <= '0;
        out_center_y      <= '0;
        out_circle_radius <= '0;
        out_fit_status    <= ST_COLLINEAR;
      end else begin
        out_center_x      <= cx_rr;
        out_center_y      <= cy_rr;
        out_circle_radius <= rsat_fin ? {CW{1'b1}} : rad_rr[CW-1:0];
        out_fit_status    <= (satc_rr || rsat_fin) ? ST_SATURATED : ST_VALID;
      end
    end
  end

endmodule

// ===== sv/tpcf_checker.sv =====
// ----------------------------------------------------------------------------
// tpcf_checker
// Port-level checks for the three-point circle fit, bound to the top level.
// ----------------------------------------------------------------------------
module tpcf_checker
  import tpcf_pkg::*;
#(
  parameter int COORD_WIDTH = TPCF_COORD_WIDTH
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [COORD_WIDTH-1:0] out_center_x,
  input logic signed [COORD_WIDTH-1:0] out_center_y,
  input logic [COORD_WIDTH-1:0]        out_circle_radius,
  input logic [STATUS_W-1:0]           out_fit_status
);

  // input only backs up when a result beat is held at the output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output beat");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fit_status == ST_VALID || out_fit_status == ST_COLLINEAR ||
                   out_fit_status == ST_SATURATED))
    else $error("undefined fit status");

  a_collinear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fit_status == ST_COLLINEAR) |->
      (out_center_x == '0 && out_center_y == '0 && out_circle_radius == '0))
    else $error("collinear beat with nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_center_x) &&
      $stable(out_center_y) && $stable(out_circle_radius) && $stable(out_fit_status)))
    else $error("stalled output beat changed");

endmodule

bind three_point_circle_fit tpcf_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tpcf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_center_x      (out_center_x),
  .out_center_y      (out_center_y),
  .out_circle_radius (out_circle_radius),
  .out_fit_status    (out_fit_status)
);
